[hdl/tag_attribute_value_extractor_macros.svh]
// assertion macros for the tag attribute value extractor
`ifndef TAG_ATTRIBUTE_VALUE_EXTRACTOR_MACROS_SVH
`define TAG_ATTRIBUTE_VALUE_EXTRACTOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TAVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be true outside reset
`define TAVE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/tave_pkg.sv]
// shared types and constants for the tag attribute value extractor
`default_nettype none

package tave_pkg;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_OFFS  = 8'h20;

  localparam int unsigned SKIP_BYTES = 2;
  localparam int unsigned SKIP_W     = 1;

  localparam int unsigned PAT_W   = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 64;

  typedef enum logic [1:0] {
    REG_TAG_PATTERN  = 2'd0,
    REG_TAG_LENGTH   = 2'd1,
    REG_PROP_PATTERN = 2'd2,
    REG_PROP_LENGTH  = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_PROP = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_EMIT = 4'b1000
  } phase_e;

endpackage

`default_nettype wire

[hdl/tag_attribute_value_extractor.sv]
// top level of the tag attribute value extractor
//
// input channel: one text byte per transfer with an end-of-text flag, using
// in_valid_i / in_stall_o. output channel: one value byte or an end-of-value
// marker per transfer, using out_valid_o / out_stall_i.
// the block hunts for the configured tag, then the configured property name,
// drops the next two bytes, then forwards lower-cased bytes until a double
// quote, which yields a marker with value_byte zero and value_done high.
// a byte is taken every cycle while in_stall_o is low; a result is offered at
// the output once the input register has loaded its input byte and the
// result register has loaded it from the single compare and update step.
// a stalled result holds in the result register; the input register keeps
// taking bytes that produce no result, and stalls only when a new result
// would need the occupied result register.
// reset clears the search state, both valid flags and the pattern registers
// (patterns zero, lengths one). the apb port (psel/penable/pwrite/paddr/
// pwdata/prdata/pready) writes the four registers at byte addresses 0, 8,
// 16 and 24; the user must write it only while the block is idle (unchecked).
`default_nettype none

module tag_attribute_value_extractor #(
  parameter int unsigned MAX_PATTERN_BYTES = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 text_byte_i,
  input  wire logic                       end_of_text_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [7:0]                      value_byte_o,
  output logic                            value_done_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tave_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tave_pkg::DATA_W-1:0] pwdata,
  output logic [tave_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned WIN_W = 8 * MAX_PATTERN_BYTES;
  localparam int unsigned CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  // configuration registers
  logic [tave_pkg::PAT_W-1:0] tag_pat_q, prop_pat_q;
  logic [tave_pkg::LEN_W-1:0] tag_len_q, prop_len_q;
  tave_pkg::reg_idx_e         reg_idx;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = tave_pkg::reg_idx_e'(paddr[4:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_pat_q  <= '0;
      tag_len_q  <= tave_pkg::LEN_W'(1);
      prop_pat_q <= '0;
      prop_len_q <= tave_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tave_pkg::REG_TAG_PATTERN:  tag_pat_q  <= pwdata;
        tave_pkg::REG_TAG_LENGTH:   tag_len_q  <= pwdata[tave_pkg::LEN_W-1:0];
        tave_pkg::REG_PROP_PATTERN: prop_pat_q <= pwdata;
        tave_pkg::REG_PROP_LENGTH:  prop_len_q <= pwdata[tave_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tave_pkg::REG_TAG_PATTERN:  prdata = tag_pat_q;
      tave_pkg::REG_TAG_LENGTH:   prdata = tave_pkg::DATA_W'(tag_len_q);
      tave_pkg::REG_PROP_PATTERN: prdata = prop_pat_q;
      tave_pkg::REG_PROP_LENGTH:  prdata = tave_pkg::DATA_W'(prop_len_q);
      default:                    prdata = '0;
    endcase
  end

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_eot_q;
  logic       s1_adv;
  logic       s1_has_res;
  logic       in_take;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_done_q, out_done_d;

  // search state
  tave_pkg::phase_e            phase_q, phase_d;
  logic [WIN_W-1:0]            recent_q, recent_d;
  logic [CNT_W-1:0]            bip_q, bip_d;
  logic [tave_pkg::SKIP_W-1:0] skip_q, skip_d;

  assign s1_has_res = (phase_q == tave_pkg::PH_EMIT);
  assign s1_adv     = s1_valid_q & (~s1_has_res | ~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_take | (s1_valid_q & ~s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= text_byte_i;
      s1_eot_q  <= end_of_text_i;
    end
  end

  // window compare
  logic [WIN_W-1:0] win;
  logic [CNT_W-1:0] bip_inc;
  logic [CNT_W-1:0] tag_len_eff, prop_len_eff, len_eff;
  logic [7:0]       win_lane [MAX_PATTERN_BYTES];
  logic [7:0]       pat_lane [MAX_PATTERN_BYTES];
  logic [tave_pkg::PAT_W-1:0] pat_sel;
  logic [IDX_W-1:0] k;
  logic             hit;

  always_comb begin
    if (tag_len_q == '0) begin
      tag_len_eff = CNT_W'(1);
    end else if (tag_len_q > tave_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
      tag_len_eff = CNT_W'(MAX_PATTERN_BYTES);
    end else begin
      tag_len_eff = CNT_W'(tag_len_q);
    end
    if (prop_len_q == '0) begin
      prop_len_eff = CNT_W'(1);
    end else if (prop_len_q > tave_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
      prop_len_eff = CNT_W'(MAX_PATTERN_BYTES);
    end else begin
      prop_len_eff = CNT_W'(prop_len_q);
    end
  end

  always_comb begin
    win     = WIN_W'({recent_q, s1_byte_q});
    bip_inc = (bip_q < CNT_W'(MAX_PATTERN_BYTES)) ? bip_q + CNT_W'(1) : bip_q;
    if (phase_q == tave_pkg::PH_TAG) begin
      pat_sel = tag_pat_q;
      len_eff = tag_len_eff;
    end else begin
      pat_sel = prop_pat_q;
      len_eff = prop_len_eff;
    end
    hit = (bip_inc >= len_eff);
    k   = '0;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      win_lane[j] = win[8*j +: 8];
      pat_lane[j] = pat_sel[8*j +: 8];
    end
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      if (CNT_W'(j) < len_eff) begin
        k = IDX_W'(len_eff - CNT_W'(j) - CNT_W'(1));
        if (win_lane[j] != pat_lane[k]) begin
          hit = 1'b0;
        end
      end
    end
  end

  // state update and result
  always_comb begin
    phase_d     = phase_q;
    recent_d    = recent_q;
    bip_d       = bip_q;
    skip_d      = skip_q;
    out_byte_d  = out_byte_q;
    out_done_d  = out_done_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (s1_adv) begin
      unique case (phase_q)
        tave_pkg::PH_TAG, tave_pkg::PH_PROP: begin
          recent_d = win;
          bip_d    = bip_inc;
          if (hit) begin
            recent_d = '0;
            bip_d    = '0;
            skip_d   = '0;
            phase_d  = (phase_q == tave_pkg::PH_TAG) ? tave_pkg::PH_PROP : tave_pkg::PH_SKIP;
          end
        end
        tave_pkg::PH_SKIP: begin
          if (skip_q == tave_pkg::SKIP_W'(tave_pkg::SKIP_BYTES - 1)) begin
            skip_d  = '0;
            phase_d = tave_pkg::PH_EMIT;
          end else begin
            skip_d = skip_q + tave_pkg::SKIP_W'(1);
          end
        end
        tave_pkg::PH_EMIT: begin
          out_valid_d = 1'b1;
          if (s1_byte_q == tave_pkg::QUOTE_BYTE) begin
            out_byte_d = '0;
            out_done_d = 1'b1;
            phase_d    = tave_pkg::PH_TAG;
          end else begin
            out_done_d = 1'b0;
            if (s1_byte_q >= tave_pkg::UPPER_A && s1_byte_q <= tave_pkg::UPPER_Z) begin
              out_byte_d = s1_byte_q + tave_pkg::CASE_OFFS;
            end else begin
              out_byte_d = s1_byte_q;
            end
          end
        end
        default: phase_d = tave_pkg::PH_TAG;
      endcase
      if (s1_eot_q) begin
        phase_d  = tave_pkg::PH_TAG;
        recent_d = '0;
        bip_d    = '0;
        skip_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tave_pkg::PH_TAG;
      recent_q    <= '0;
      bip_q       <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      recent_q    <= recent_d;
      bip_q       <= bip_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o  = out_valid_q;
  assign value_byte_o = out_byte_q;
  assign value_done_o = out_done_q;

  `include "tag_attribute_value_extractor_macros.svh"

  `TAVE_ASSERT(bip_bounded, bip_q <= CNT_W'(MAX_PATTERN_BYTES), "phase byte count overflow")
  `TAVE_ASSERT_NEVER(window_outside_search,
      (phase_q == tave_pkg::PH_SKIP || phase_q == tave_pkg::PH_EMIT) &&
      (recent_q != '0 || bip_q != '0),
      "window not cleared outside search")
  `TAVE_ASSERT(skip_only_in_skip,
      skip_q != '0 |-> phase_q == tave_pkg::PH_SKIP,
      "skip count set outside skip phase")
  `TAVE_ASSERT(eot_restarts,
      s1_adv && s1_eot_q |=> phase_q == tave_pkg::PH_TAG && bip_q == '0,
      "end of text did not restart search")
  `TAVE_ASSERT(emit_fills_result,
      s1_adv && s1_has_res |=> out_valid_q,
      "emitted byte lost")

endmodule

`default_nettype wire
